// ===== rtl/ppsd_pkg.sv =====
package ppsd_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_DUTY   = 2'd2;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_PWM      = 2'd2;

    localparam logic [2:0] REG_MAX_POSITION  = 3'd0;
    localparam logic [2:0] REG_MIN_POSITION  = 3'd1;
    localparam logic [2:0] REG_KP            = 3'd2;
    localparam logic [2:0] REG_KI            = 3'd3;
    localparam logic [2:0] REG_KD            = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT     = 3'd5;
    localparam logic [2:0] REG_TOLERANCE     = 3'd6;
    localparam logic [2:0] REG_STALL_LIMIT   = 3'd7;

    localparam logic signed [15:0] DRIVE_MAX = 16'sd32767;
    // DRIVE_MAX * 2^9: drive accumulator level at which the output saturates
    localparam logic signed [67:0] SAT_LEVEL = 68'sd16776704;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_DUTY   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
        logic signed [31:0] position;
        logic signed [15:0] speed;
    } entry_t;

    typedef struct packed {
        logic signed [31:0] max_position;
        logic signed [31:0] min_position;
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic [30:0]        integral_limit;
        logic [15:0]        reach_tol;
        logic [15:0]        stall_limit_ticks;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic               drive_valid;
        logic signed [15:0] drive_level;
        logic               at_target;
        logic               stall_flag;
        logic               target_event;
        logic               stall_event;
    } result_t;

endpackage

// ===== rtl/ppsd_if.sv =====
interface ppsd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] command_value;
    logic signed [31:0] measured_position;
    logic signed [15:0] measured_speed;

    modport source (
        output valid, operation, command_value, measured_position, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, operation, command_value, measured_position, measured_speed,
        output ready
    );
endinterface

interface ppsd_out_if;
    logic               valid;
    logic               ready;
    logic               drive_valid;
    logic signed [15:0] drive_level;
    logic               at_target;
    logic               stall_flag;
    logic               target_event;
    logic               stall_event;

    modport source (
        output valid, drive_valid, drive_level, at_target, stall_flag,
               target_event, stall_event,
        input  ready
    );
    modport sink (
        input  valid, drive_valid, drive_level, at_target, stall_flag,
               target_event, stall_event,
        output ready
    );
endinterface

// ===== rtl/ppsd_front.sv =====
module ppsd_front (
    ppsd_in_if.sink              command,
    input  ppsd_pkg::cfg_t       cfg,
    input  ppsd_pkg::q_status_t  q_status,
    output logic                 push,
    output ppsd_pkg::entry_t     entry
);

    logic signed [31:0] lim_hi;
    logic signed [31:0] lim_lo;
    logic signed [31:0] target_clamped;
    logic signed [31:0] duty_clamped;
    logic signed [31:0] duty_max;

    assign command.ready = !q_status.full;
    assign push          = command.valid && !q_status.full;

    assign duty_max = 32'(ppsd_pkg::DRIVE_MAX);

    always_comb
    begin
        // reversed limits are swapped
        if (cfg.max_position < cfg.min_position)
        begin
            lim_hi = cfg.min_position;
            lim_lo = cfg.max_position;
        end
        else
        begin
            lim_hi = cfg.max_position;
            lim_lo = cfg.min_position;
        end

        if (command.command_value < lim_lo)
            target_clamped = lim_lo;
        else if (command.command_value > lim_hi)
            target_clamped = lim_hi;
        else
            target_clamped = command.command_value;

        if (command.command_value < -duty_max)
            duty_clamped = -duty_max;
        else if (command.command_value > duty_max)
            duty_clamped = duty_max;
        else
            duty_clamped = command.command_value;
    end

    always_comb
    begin
        entry.position = command.measured_position;
        entry.speed    = command.measured_speed;
        case (command.operation)
            ppsd_pkg::OP_TICK:
            begin
                entry.kind  = ppsd_pkg::KIND_TICK;
                entry.value = command.command_value;
            end
            ppsd_pkg::OP_TARGET:
            begin
                entry.kind  = ppsd_pkg::KIND_TARGET;
                entry.value = target_clamped;
            end
            ppsd_pkg::OP_DUTY:
            begin
                entry.kind  = ppsd_pkg::KIND_DUTY;
                entry.value = duty_clamped;
            end
            default:
            begin
                entry.kind  = ppsd_pkg::KIND_NOP;
                entry.value = command.command_value;
            end
        endcase
    end

endmodule

// ===== rtl/ppsd_queue.sv =====
module ppsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ppsd_pkg::entry_t     wr_data,
    input  logic                 pop,
    output ppsd_pkg::entry_t     rd_data,
    output ppsd_pkg::q_status_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppsd_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/ppsd_back.sv =====
module ppsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppsd_pkg::cfg_t       cfg,
    input  ppsd_pkg::q_status_t  q_status,
    input  ppsd_pkg::entry_t     q_data,
    output logic                 pop,
    ppsd_out_if.source           result
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MP   = 6'b000010,
        ST_MI   = 6'b000100,
        ST_MD   = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // controller state
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic signed [31:0] target_reg;
    logic signed [31:0] target_next;
    logic signed [15:0] drive_reg;
    logic signed [15:0] drive_next;
    logic signed [31:0] esum_reg;
    logic signed [31:0] esum_next;
    logic signed [32:0] last_err_reg;
    logic [15:0]        stall_cnt_reg;
    logic [15:0]        stall_cnt_next;
    logic               reach_rep_reg;
    logic               reach_rep_next;
    logic               stall_rep_reg;
    logic               stall_rep_next;

    // per-item work registers
    ppsd_pkg::entry_t   item_reg;
    logic signed [32:0] err_reg;
    logic signed [33:0] deriv_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;
    logic signed [67:0] acc_reg;
    logic signed [67:0] acc_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    ppsd_pkg::result_t    res_reg;
    ppsd_pkg::result_t    res_next;

    logic                 commit;
    logic signed [31:0]   mul_a;
    logic signed [33:0]   mul_b;
    logic signed [33:0]   esum_sum;
    logic signed [33:0]   esum_lim;
    logic signed [33:0]   esum_clamped;
    logic signed [24:0]   trunc_sum;
    logic signed [15:0]   pid_level;
    logic [32:0]          err_mag;
    logic                 reached;
    logic                 stalled;

    assign commit = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
    assign pop    = (state_reg == ST_IDLE) && !q_status.empty;

    // shared multiplier: kp*err, ki*error_sum, kd*deriv in successive cycles
    always_comb
    begin
        case (state_reg)
            ST_MP:
            begin
                mul_a = cfg.kp;
                mul_b = 34'(err_reg);
            end
            ST_MI:
            begin
                mul_a = cfg.ki;
                mul_b = 34'(esum_reg);
            end
            default:
            begin
                mul_a = cfg.kd;
                mul_b = deriv_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign esum_sum = 34'(esum_reg) + 34'(err_reg);
    assign esum_lim = $signed({3'b000, cfg.integral_limit});

    always_comb
    begin
        if (esum_sum > esum_lim)
            esum_clamped = esum_lim;
        else if (esum_sum < -esum_lim)
            esum_clamped = -esum_lim;
        else
            esum_clamped = esum_sum;
    end

    // drive = acc / 2^9 toward zero, saturated
    assign trunc_sum = $signed(acc_reg[24:0]) + (acc_reg[67] ? 25'sd511 : 25'sd0);

    always_comb
    begin
        if (acc_reg >= ppsd_pkg::SAT_LEVEL)
            pid_level = ppsd_pkg::DRIVE_MAX;
        else if (acc_reg <= -ppsd_pkg::SAT_LEVEL)
            pid_level = -ppsd_pkg::DRIVE_MAX;
        else
            pid_level = 16'(trunc_sum >>> 9);
    end

    assign err_mag = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
    assign reached = err_mag < 33'(cfg.reach_tol);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        esum_next      = esum_reg;
        mode_next      = mode_reg;
        target_next    = target_reg;
        drive_next     = drive_reg;
        stall_cnt_next = stall_cnt_reg;
        reach_rep_next = reach_rep_reg;
        stall_rep_next = stall_rep_reg;
        res_next       = '0;
        stalled        = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (q_data.kind == ppsd_pkg::KIND_TICK && mode_reg == ppsd_pkg::MODE_POSITION)
                        state_next = ST_MP;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_MP:
            begin
                if (cfg.ki != '0)
                    esum_next = esum_clamped[31:0];
                state_next = ST_MI;
            end
            ST_MI:
            begin
                acc_next   = 68'(prod_reg);
                state_next = ST_MD;
            end
            ST_MD:
            begin
                acc_next   = acc_reg + 68'(prod_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = acc_reg + 68'(prod_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                case (item_reg.kind)
                    ppsd_pkg::KIND_TICK:
                    begin
                        if (mode_reg == ppsd_pkg::MODE_POSITION)
                            drive_next = pid_level;
                        res_next.drive_valid    = (mode_reg != ppsd_pkg::MODE_NONE);
                        res_next.drive_level    = (mode_reg != ppsd_pkg::MODE_NONE) ?
                                                  drive_next : 16'sd0;
                        res_next.at_target      = reached;
                        if (reached || item_reg.speed != '0 || drive_next == '0)
                        begin
                            stall_cnt_next = '0;
                        end
                        else
                        begin
                            if (stall_cnt_reg != 16'hFFFF)
                                stall_cnt_next = stall_cnt_reg + 1'b1;
                            stalled = stall_cnt_next > cfg.stall_limit_ticks;
                        end
                        res_next.stall_flag    = stalled;
                        res_next.target_event  = reached && !reach_rep_reg;
                        res_next.stall_event   = stalled && !stall_rep_reg;
                        if (reached)
                            reach_rep_next = 1'b1;
                        if (stalled)
                            stall_rep_next = 1'b1;
                    end
                    ppsd_pkg::KIND_TARGET:
                    begin
                        target_next    = item_reg.value;
                        mode_next      = ppsd_pkg::MODE_POSITION;
                        reach_rep_next = 1'b0;
                        stall_rep_next = 1'b0;
                    end
                    ppsd_pkg::KIND_DUTY:
                    begin
                        drive_next     = item_reg.value[15:0];
                        mode_next      = ppsd_pkg::MODE_PWM;
                        reach_rep_next = 1'b0;
                        stall_rep_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase

                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mode_next      = mode_reg;
                    target_next    = target_reg;
                    drive_next     = drive_reg;
                    stall_cnt_next = stall_cnt_reg;
                    reach_rep_next = reach_rep_reg;
                    stall_rep_next = stall_rep_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= ppsd_pkg::MODE_NONE;
            target_reg    <= '0;
            drive_reg     <= '0;
            esum_reg      <= '0;
            last_err_reg  <= '0;
            stall_cnt_reg <= '0;
            reach_rep_reg <= 1'b0;
            stall_rep_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            target_reg    <= target_next;
            drive_reg     <= drive_next;
            esum_reg      <= esum_next;
            stall_cnt_reg <= stall_cnt_next;
            reach_rep_reg <= reach_rep_next;
            stall_rep_reg <= stall_rep_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_MP)
                last_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_data;
            err_reg  <= 33'(target_reg) - 33'(q_data.position);
        end
        if (state_reg == ST_MP)
            deriv_reg <= 34'(err_reg) - 34'(last_err_reg);
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (commit)
            res_reg <= res_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.drive_valid    = res_reg.drive_valid;
    assign result.drive_level    = res_reg.drive_level;
    assign result.at_target      = res_reg.at_target;
    assign result.stall_flag     = res_reg.stall_flag;
    assign result.target_event   = res_reg.target_event;
    assign result.stall_event    = res_reg.stall_event;

endmodule

// ===== rtl/position_pid_with_stall_detect.sv =====
// Position PID controller with open-loop duty mode, target-reach and stall detect.
// command (valid/ready): operation, command_value, measured_position,
//   measured_speed. Operation 0 is a control tick, 1 sets the target
//   (clamped to the position limits), 2 sets the open-loop duty.
// result (valid/ready): one transfer per command transfer, in order, carrying
//   drive_valid, drive_level (Q1.15), at_target, stall_flag and the
//   one-shot target_event / stall_event.
// cfg_write/cfg_index/cfg_data write the eight setup registers; write only
//   while no command is in flight.
// A position-mode tick runs through the execution engine in order: it forms
//   the error, makes three passes through the single shared 32x34 multiplier,
//   does a final add and ends in its output step. Every other command goes
//   straight to the output step. Results are held in an output register.
// Commands are taken into a QUEUE_DEPTH-entry queue whenever it has room, so
//   the source keeps streaming while the engine works. A result waits in the
//   output register when the receiver stalls; the engine then holds in its
//   output cycle and the queue fills before command.ready drops.
// Reset clears mode, target, drive, integral, last error, stall count and
//   event flags, and loads the setup registers with their defaults.
module position_pid_with_stall_detect #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    ppsd_in_if.sink     command,
    ppsd_out_if.source  result,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ppsd_pkg::cfg_t       cfg_reg;
    ppsd_pkg::q_status_t  q_status;
    ppsd_pkg::entry_t     q_wr_data;
    ppsd_pkg::entry_t     q_rd_data;
    logic                 q_push;
    logic                 q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_position       <= 32'sh7FFF_FFFF;
            cfg_reg.min_position       <= 32'sh8000_0000;
            cfg_reg.kp                 <= '0;
            cfg_reg.ki                 <= '0;
            cfg_reg.kd                 <= '0;
            cfg_reg.integral_limit     <= '0;
            cfg_reg.reach_tol          <= 16'd1;
            cfg_reg.stall_limit_ticks  <= 16'd100;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ppsd_pkg::REG_MAX_POSITION: cfg_reg.max_position       <= cfg_data;
                ppsd_pkg::REG_MIN_POSITION: cfg_reg.min_position       <= cfg_data;
                ppsd_pkg::REG_KP:           cfg_reg.kp                 <= cfg_data;
                ppsd_pkg::REG_KI:           cfg_reg.ki                 <= cfg_data;
                ppsd_pkg::REG_KD:           cfg_reg.kd                 <= cfg_data;
                ppsd_pkg::REG_INT_LIMIT:    cfg_reg.integral_limit     <= cfg_data[30:0];
                ppsd_pkg::REG_TOLERANCE:    cfg_reg.reach_tol          <= cfg_data[15:0];
                ppsd_pkg::REG_STALL_LIMIT:  cfg_reg.stall_limit_ticks  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    ppsd_front u_front (
        .command  (command),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (q_push),
        .entry    (q_wr_data)
    );

    ppsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    ppsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .pop      (q_pop),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_idle_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.drive_valid) |-> (result.drive_level == 16'sd0))
        else $error("drive level nonzero without drive");

    a_event_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((!result.target_event || result.at_target) &&
                          (!result.stall_event || result.stall_flag)))
        else $error("event without its condition");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.drive_level != 16'sh8000))
        else $error("drive level out of range");
`endif

endmodule
